>>> src/nqfs_pkg.sv
// Shared types for the n-queens first-solution search block.
// Holds the command and status bundles between controller and datapath.
// No dependencies.
package nqfs_pkg;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic init;         // clear row, candidate and emit index for a new search
    logic place;        // store candidate in current row, advance to next row
    logic check_start;  // begin comparing against row 0
    logic check_next;   // advance to the next earlier row
    logic reject;       // candidate conflicts, try next column
    logic back_step;    // step back one row
    logic back_load;    // resume that row one column past its old queen
    logic emit_sel;     // table read address follows the emit index
    logic emit_load;    // load one found row into the output register
    logic fail_load;    // load the no-solution word into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic row_ge_n;     // every row holds a queen
    logic cand_ge_n;    // columns of this row are used up
    logic row_zero;     // current row is the first one
    logic conflict;     // candidate shares a column or diagonal with checked row
    logic check_last;   // checked row is the one just above the current row
    logic emit_last;    // emit index points at the final row
    logic out_busy;     // output register holds a word that is stalled
  } sts_t;

endpackage

>>> src/nqfs_dp.sv
// Datapath of the n-queens search: board size register, column table,
// search counters, conflict test and output register. Uses nqfs_pkg.
module nqfs_dp #(
  parameter int MAX_BOARD = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [3:0]     cfg_wdata,
  input  nqfs_pkg::cmd_t cmd,
  output nqfs_pkg::sts_t sts,
  input  logic           out_stall,
  output logic           out_valid,
  output logic [2:0]     out_row_index,
  output logic [2:0]     out_queen_column,
  output logic           out_found,
  output logic           out_last
);
  import nqfs_pkg::*;

  localparam int CW = $clog2(MAX_BOARD);
  localparam int RW = $clog2(MAX_BOARD + 1);
  localparam int BW = (RW > 4) ? RW : 4;

  logic [3:0]    board_size_r;
  logic [CW-1:0] qc_r [MAX_BOARD];
  logic [RW-1:0] row_r, row_nxt;
  logic [RW-1:0] cand_r, cand_nxt;
  logic [CW-1:0] chk_r, chk_nxt;
  logic [CW-1:0] emit_r, emit_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [2:0]    out_row_r, out_col_r;
  logic          out_found_r, out_last_r;

  logic [BW-1:0] bs_ext;
  logic [RW-1:0] n_eff;
  logic [CW-1:0] rd_addr;
  logic [CW-1:0] qc_rd;
  logic [RW-1:0] qc_ext, dc, dr;
  logic [CW+2:0] emit_wide, col_wide;

  // Board size zero runs as one; sizes above the table depth saturate.
  assign bs_ext = BW'(board_size_r);
  always_comb begin
    if (bs_ext == '0) begin
      n_eff = RW'(1);
    end else if (bs_ext > BW'(MAX_BOARD)) begin
      n_eff = RW'(MAX_BOARD);
    end else begin
      n_eff = RW'(bs_ext);
    end
  end

  // One read port on the column table, shared by check, backtrack and emit.
  always_comb begin
    if (cmd.back_load) begin
      rd_addr = row_r[CW-1:0];
    end else if (cmd.emit_sel) begin
      rd_addr = emit_r;
    end else begin
      rd_addr = chk_r;
    end
  end
  assign qc_rd = qc_r[rd_addr];

  assign qc_ext = RW'(qc_rd);
  assign dc     = (cand_r >= qc_ext) ? (cand_r - qc_ext) : (qc_ext - cand_r);
  assign dr     = row_r - RW'(chk_r);

  assign sts.row_ge_n   = (row_r >= n_eff);
  assign sts.cand_ge_n  = (cand_r >= n_eff);
  assign sts.row_zero   = (row_r == '0);
  assign sts.conflict   = (dc == '0) || (dc == dr);
  assign sts.check_last = ((RW'(chk_r) + RW'(1)) == row_r);
  assign sts.emit_last  = ((RW'(emit_r) + RW'(1)) == n_eff);
  assign sts.out_busy   = out_valid_r && out_stall;

  always_comb begin
    row_nxt  = row_r;
    cand_nxt = cand_r;
    chk_nxt  = chk_r;
    emit_nxt = emit_r;
    if (cmd.init) begin
      row_nxt  = '0;
      cand_nxt = '0;
      emit_nxt = '0;
    end
    if (cmd.place) begin
      row_nxt  = row_r + RW'(1);
      cand_nxt = '0;
    end
    if (cmd.reject) begin
      cand_nxt = cand_r + RW'(1);
    end
    if (cmd.check_start) begin
      chk_nxt = '0;
    end
    if (cmd.check_next) begin
      chk_nxt = chk_r + CW'(1);
    end
    if (cmd.back_step) begin
      row_nxt = row_r - RW'(1);
    end
    if (cmd.back_load) begin
      cand_nxt = qc_ext + RW'(1);
    end
    if (cmd.emit_load) begin
      emit_nxt = emit_r + CW'(1);
    end
  end

  // Output register: cleared when taken; the controller reloads it only when it is not stalled.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.emit_load || cmd.fail_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  assign emit_wide = {3'b000, emit_r};
  assign col_wide  = {3'b000, qc_rd};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      board_size_r <= 4'd4;
      row_r        <= '0;
      cand_r       <= '0;
      chk_r        <= '0;
      emit_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        board_size_r <= cfg_wdata;
      end
      row_r       <= row_nxt;
      cand_r      <= cand_nxt;
      chk_r       <= chk_nxt;
      emit_r      <= emit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.place) begin
      qc_r[row_r[CW-1:0]] <= cand_r[CW-1:0];
    end
    if (cmd.emit_load) begin
      out_row_r   <= emit_wide[2:0];
      out_col_r   <= col_wide[2:0];
      out_found_r <= 1'b1;
      out_last_r  <= sts.emit_last;
    end else if (cmd.fail_load) begin
      out_row_r   <= 3'd0;
      out_col_r   <= 3'd0;
      out_found_r <= 1'b0;
      out_last_r  <= 1'b1;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_row_index    = out_row_r;
  assign out_queen_column = out_col_r;
  assign out_found        = out_found_r;
  assign out_last         = out_last_r;

endmodule

>>> src/nqfs_ctrl.sv
// Controller of the n-queens search: sequences start, scan, row checks,
// backtracking and result output. Uses nqfs_pkg.
module nqfs_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_start_req,
  output logic           in_stall,
  input  nqfs_pkg::sts_t sts,
  output nqfs_pkg::cmd_t cmd
);
  import nqfs_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_BACK  = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;
  localparam logic [2:0] ST_FAIL  = 3'd5;

  logic [2:0] state_r, state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_start_req) begin
          cmd.init  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.row_ge_n) begin
          state_nxt = ST_EMIT;
        end else if (sts.cand_ge_n) begin
          if (sts.row_zero) begin
            state_nxt = ST_FAIL;
          end else begin
            cmd.back_step = 1'b1;
            state_nxt     = ST_BACK;
          end
        end else if (sts.row_zero) begin
          // The first row has nothing above it to conflict with.
          cmd.place = 1'b1;
        end else begin
          cmd.check_start = 1'b1;
          state_nxt       = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.conflict) begin
          cmd.reject = 1'b1;
          state_nxt  = ST_SCAN;
        end else if (sts.check_last) begin
          cmd.place = 1'b1;
          state_nxt = ST_SCAN;
        end else begin
          cmd.check_next = 1'b1;
        end
      end
      ST_BACK: begin
        cmd.back_load = 1'b1;
        state_nxt     = ST_SCAN;
      end
      ST_EMIT: begin
        cmd.emit_sel = 1'b1;
        if (!sts.out_busy) begin
          cmd.emit_load = 1'b1;
          if (sts.emit_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_FAIL: begin
        if (!sts.out_busy) begin
          cmd.fail_load = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> src/n_queens_first_solution.sv
// Top level of the n-queens first-solution search block.
// Instantiates nqfs_ctrl and nqfs_dp; uses nqfs_pkg.
//
// Usage: the board size n (1 to MAX_BOARD; zero runs as one, larger values
// saturate) is written through cfg_we/cfg_wdata while the block is idle and
// resets to 4. A word on the input channel with start_req set launches one
// depth-first backtracking search; a word with start_req clear is taken and
// dropped without a result.
//
// The search fills rows in order and tries columns from zero upward. Each
// candidate is scanned and then compared against the earlier rows one at a
// time, up to the first conflict, and each backtrack steps back a row and
// reloads its old queen, so the search time is set by the single-port column
// table walked by the check counter.
//
// When a placement is found, n result words follow, one per row, with
// row_index, queen_column, found set and last on the final row. When none
// exists (n of 2 or 3) a single word with found clear and last set follows.
// in_stall stays high from the accepted start until the last result word has
// entered the output register, so one search runs at a time; the next start
// may be taken while that last word still waits. A stalled output holds its
// word and pauses the result sequence. Reset is synchronous and active low:
// it returns the controller to idle, empties the output register and sets the
// board size back to 4.
module n_queens_first_solution #(
  parameter int MAX_BOARD = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_start_req,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_row_index,
  output logic [2:0] out_queen_column,
  output logic       out_found,
  output logic       out_last
);
  import nqfs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The controller owns sequencing only; all counters live in the datapath.
  nqfs_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_start_req (in_start_req),
    .in_stall     (in_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  nqfs_dp #(
    .MAX_BOARD (MAX_BOARD)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .cmd              (cmd),
    .sts              (sts),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_row_index    (out_row_index),
    .out_queen_column (out_queen_column),
    .out_found        (out_found),
    .out_last         (out_last)
  );

endmodule

>>> src/nqfs_checker.sv
// Port-level checker for the n-queens search block and its bind statement.
// Depends only on the ports of n_queens_first_solution.
module nqfs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       in_start_req,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] out_row_index,
  input logic [2:0] out_queen_column,
  input logic       out_found,
  input logic       out_last
);

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output word present after reset");

  // A taken start word begins a search, so the input is refused right after.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_start_req |=> in_stall)
    else $error("input not stalled after a start word");

  // A stalled word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_row_index) &&
      $stable(out_queen_column) && $stable(out_found) && $stable(out_last))
    else $error("stalled output word changed");

  // The no-solution word stands alone and is all zeros apart from last.
  a_fail_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_last && out_row_index == 3'd0 &&
      out_queen_column == 3'd0)
    else $error("malformed no-solution word");

  // Rows of a solution come out in order, one after the other.
  a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=>
      !out_valid || (out_row_index == $past(out_row_index) + 3'd1))
    else $error("solution rows out of order");

endmodule

bind n_queens_first_solution nqfs_checker u_nqfs_checker (.*);
